// File: sv/tiled_led_pixel_mapper_unit_defines.svh
`ifndef TILED_LED_PIXEL_MAPPER_UNIT_DEFINES_SVH
`define TILED_LED_PIXEL_MAPPER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TLPM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlpm check failed");

// next-cycle implication, sampled on clk, off during reset
`define TLPM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlpm check failed");

`endif

// File: sv/tlpm_pkg.sv
package tlpm_pkg;

    localparam int COORD_BITS_DEF     = 12;
    localparam int BRIGHTNESS_MAX_DEF = 255;
    localparam int COORD_MAX_BITS     = 16;
    localparam int PIXEL_BITS         = 12;
    localparam int SEG_BITS           = 7;
    localparam int LEVEL_BITS         = 8;
    localparam int CHAN_BITS          = 8;
    localparam int IDX_BITS           = 24;
    localparam int CFG_DATA_BITS      = 8;
    localparam int CFG_INDEX_BITS     = 2;
    localparam int INNER_BITS         = 2 * SEG_BITS;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t CFG_SEG_WIDTH   = 2'd0;
    localparam cfg_index_t CFG_SEG_HEIGHT  = 2'd1;
    localparam cfg_index_t CFG_SEG_COLUMNS = 2'd2;
    localparam cfg_index_t CFG_BRIGHTNESS  = 2'd3;

    localparam logic [SEG_BITS-1:0]   SEG_WIDTH_RST   = 7'd8;
    localparam logic [SEG_BITS-1:0]   SEG_HEIGHT_RST  = 7'd8;
    localparam logic [SEG_BITS-1:0]   SEG_COLUMNS_RST = 7'd1;
    localparam logic [LEVEL_BITS-1:0] BRIGHTNESS_RST  = 8'd255;

    typedef struct packed {
        logic [CHAN_BITS-1:0] r;
        logic [CHAN_BITS-1:0] g;
        logic [CHAN_BITS-1:0] b;
    } rgb_t;

endpackage

// File: sv/tlpm_div_cell.sv
module tlpm_div_cell
    import tlpm_pkg::*;
#(
    parameter int CW = COORD_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [SEG_BITS-1:0] w_div,
    input  logic [SEG_BITS-1:0] h_div,
    input  logic                valid_in,
    input  logic [CW-1:0]       x_dq_in,
    input  logic [SEG_BITS-1:0] x_rem_in,
    input  logic [CW-1:0]       y_dq_in,
    input  logic [SEG_BITS-1:0] y_rem_in,
    input  rgb_t                rgb_in,
    output logic                valid_out,
    output logic [CW-1:0]       x_dq_out,
    output logic [SEG_BITS-1:0] x_rem_out,
    output logic [CW-1:0]       y_dq_out,
    output logic [SEG_BITS-1:0] y_rem_out,
    output rgb_t                rgb_out
);

    logic                valid_reg;
    logic [CW-1:0]       x_dq_reg;
    logic [CW-1:0]       x_dq_next;
    logic [SEG_BITS-1:0] x_rem_reg;
    logic [SEG_BITS-1:0] x_rem_next;
    logic [CW-1:0]       y_dq_reg;
    logic [CW-1:0]       y_dq_next;
    logic [SEG_BITS-1:0] y_rem_reg;
    logic [SEG_BITS-1:0] y_rem_next;
    rgb_t                rgb_reg;
    logic [SEG_BITS:0]   x_trial;
    logic [SEG_BITS:0]   x_sub;
    logic                x_ge;
    logic [SEG_BITS:0]   y_trial;
    logic [SEG_BITS:0]   y_sub;
    logic                y_ge;

    // one restoring division step per coordinate
    always_comb
    begin
        x_trial    = {x_rem_in, x_dq_in[CW-1]};
        x_sub      = x_trial - {1'b0, w_div};
        x_ge       = x_trial >= {1'b0, w_div};
        x_rem_next = x_ge ? x_sub[SEG_BITS-1:0] : x_trial[SEG_BITS-1:0];
        x_dq_next  = {x_dq_in[CW-2:0], x_ge};

        y_trial    = {y_rem_in, y_dq_in[CW-1]};
        y_sub      = y_trial - {1'b0, h_div};
        y_ge       = y_trial >= {1'b0, h_div};
        y_rem_next = y_ge ? y_sub[SEG_BITS-1:0] : y_trial[SEG_BITS-1:0];
        y_dq_next  = {y_dq_in[CW-2:0], y_ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_dq_reg  <= x_dq_next;
            x_rem_reg <= x_rem_next;
            y_dq_reg  <= y_dq_next;
            y_rem_reg <= y_rem_next;
            rgb_reg   <= rgb_in;
        end
    end

    assign valid_out = valid_reg;
    assign x_dq_out  = x_dq_reg;
    assign x_rem_out = x_rem_reg;
    assign y_dq_out  = y_dq_reg;
    assign y_rem_out = y_rem_reg;
    assign rgb_out   = rgb_reg;

endmodule

// File: sv/tlpm_out_pipe.sv
module tlpm_out_pipe
    import tlpm_pkg::*;
#(
    parameter int CW             = COORD_BITS_DEF,
    parameter int BRIGHTNESS_MAX = BRIGHTNESS_MAX_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic                  valid_in,
    input  logic [CW-1:0]         col_in,
    input  logic [SEG_BITS-1:0]   xr_in,
    input  logic [CW-1:0]         row_in,
    input  logic [SEG_BITS-1:0]   yr_in,
    input  rgb_t                  rgb_in,
    input  logic [SEG_BITS-1:0]   w_eff,
    input  logic [SEG_BITS-1:0]   h_eff,
    input  logic [SEG_BITS-1:0]   cols,
    input  logic [LEVEL_BITS-1:0] level,
    output logic                  valid_out,
    output logic [IDX_BITS-1:0]   idx_out,
    output rgb_t                  rgb_out
);

`include "tiled_led_pixel_mapper_unit_defines.svh"

    localparam int PROD_BITS  = CHAN_BITS + LEVEL_BITS;
    localparam int RSHIFT     = PROD_BITS + LEVEL_BITS;
    localparam int RECIP_BITS = RSHIFT + 1;
    localparam int MUL_BITS   = PROD_BITS + RECIP_BITS;
    localparam int ROWP_BITS  = CW + SEG_BITS;
    localparam int SEGN_BITS  = CW + SEG_BITS + 1;
    localparam int SPROD_BITS = SEGN_BITS + INNER_BITS;
    localparam longint unsigned RECIP_VAL =
        ((64'd1 << RSHIFT) + BRIGHTNESS_MAX - 1) / BRIGHTNESS_MAX;
    localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(RECIP_VAL);

    function automatic logic [CHAN_BITS-1:0] recip_scale(input logic [PROD_BITS-1:0] p);
        logic [MUL_BITS-1:0] m;
        m = MUL_BITS'(p) * MUL_BITS'(RECIP);
        return m[RSHIFT +: CHAN_BITS];
    endfunction

    function automatic logic [CHAN_BITS-1:0] floor_chan(
        input logic [CHAN_BITS-1:0] c,
        input logic [CHAN_BITS-1:0] q,
        input logic                 bypass
    );
        logic [CHAN_BITS-1:0] v;
        v = q;
        if (bypass)
            v = c;
        else if (q == '0 && c != '0)
            v = CHAN_BITS'(1);
        return v;
    endfunction

    logic                  bypass;

    // stage a: first products
    logic                  va_reg;
    logic [CW-1:0]         col_a_reg;
    logic [SEG_BITS-1:0]   xr_a_reg;
    logic [ROWP_BITS-1:0]  prow_a_reg;
    logic [INNER_BITS-1:0] pyw_a_reg;
    logic [INNER_BITS-1:0] wh_a_reg;
    logic [PROD_BITS-1:0]  pr_a_reg;
    logic [PROD_BITS-1:0]  pg_a_reg;
    logic [PROD_BITS-1:0]  pb_a_reg;
    rgb_t                  c_a_reg;

    // stage b: sums and reciprocal products
    logic                  vb_reg;
    logic [SEGN_BITS-1:0]  seg_b_reg;
    logic [SEGN_BITS-1:0]  seg_b_next;
    logic [INNER_BITS-1:0] inner_b_reg;
    logic [INNER_BITS-1:0] inner_b_next;
    logic [INNER_BITS-1:0] wh_b_reg;
    rgb_t                  q_b_reg;
    rgb_t                  q_b_next;
    rgb_t                  c_b_reg;

    // stage c: segment offset and final colour
    logic                  vc_reg;
    logic [SPROD_BITS-1:0] sprod;
    logic [IDX_BITS-1:0]   prod_c_reg;
    logic [INNER_BITS-1:0] inner_c_reg;
    rgb_t                  chan_c_reg;
    rgb_t                  chan_c_next;

    // stage d: output register
    logic                  vd_reg;
    logic [IDX_BITS-1:0]   idx_d_reg;
    logic [IDX_BITS-1:0]   idx_d_next;
    rgb_t                  rgb_d_reg;

    assign bypass = level >= LEVEL_BITS'(BRIGHTNESS_MAX);

    always_comb
    begin
        seg_b_next   = SEGN_BITS'(col_a_reg) + SEGN_BITS'(prow_a_reg);
        inner_b_next = INNER_BITS'(xr_a_reg) + pyw_a_reg;
        q_b_next.r   = recip_scale(pr_a_reg);
        q_b_next.g   = recip_scale(pg_a_reg);
        q_b_next.b   = recip_scale(pb_a_reg);

        sprod         = SPROD_BITS'(seg_b_reg) * SPROD_BITS'(wh_b_reg);
        chan_c_next.r = floor_chan(c_b_reg.r, q_b_reg.r, bypass);
        chan_c_next.g = floor_chan(c_b_reg.g, q_b_reg.g, bypass);
        chan_c_next.b = floor_chan(c_b_reg.b, q_b_reg.b, bypass);

        idx_d_next = IDX_BITS'(inner_c_reg) + prod_c_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else if (advance)
        begin
            va_reg <= valid_in;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            col_a_reg  <= col_in;
            xr_a_reg   <= xr_in;
            prow_a_reg <= ROWP_BITS'(row_in) * ROWP_BITS'(cols);
            pyw_a_reg  <= INNER_BITS'(yr_in) * INNER_BITS'(w_eff);
            wh_a_reg   <= INNER_BITS'(w_eff) * INNER_BITS'(h_eff);
            pr_a_reg   <= PROD_BITS'(rgb_in.r) * PROD_BITS'(level);
            pg_a_reg   <= PROD_BITS'(rgb_in.g) * PROD_BITS'(level);
            pb_a_reg   <= PROD_BITS'(rgb_in.b) * PROD_BITS'(level);
            c_a_reg    <= rgb_in;

            seg_b_reg   <= seg_b_next;
            inner_b_reg <= inner_b_next;
            wh_b_reg    <= wh_a_reg;
            q_b_reg     <= q_b_next;
            c_b_reg     <= c_a_reg;

            prod_c_reg  <= sprod[IDX_BITS-1:0];
            inner_c_reg <= inner_b_reg;
            chan_c_reg  <= chan_c_next;

            idx_d_reg <= idx_d_next;
            rgb_d_reg <= chan_c_reg;
        end
    end

    assign valid_out = vd_reg;
    assign idx_out   = idx_d_reg;
    assign rgb_out   = rgb_d_reg;

    `TLPM_ASSERT_NOW(a_xrem_below_width, valid_in, xr_in < w_eff)
    `TLPM_ASSERT_NOW(a_yrem_below_height, valid_in, yr_in < h_eff)
    `TLPM_ASSERT_NOW(a_scale_not_above_source, vb_reg && !bypass, q_b_reg.r <= c_b_reg.r)
    `TLPM_ASSERT_NEXT(a_result_held_when_blocked, vd_reg && !advance, vd_reg)

endmodule

// File: sv/tiled_led_pixel_mapper_unit.sv
// throughput: one pixel per clock unless out_stall halts the pipe; each pixel passes
// through the chain of COORD_BITS divider cells
// (one quotient bit per cell) followed by four arithmetic and output stages
// the whole pipe halts only while a result waits and out_stall is high
// reset: rst_n clears all valid bits and loads the register reset values
module tiled_led_pixel_mapper_unit
    import tlpm_pkg::*;
#(
    parameter int BRIGHTNESS_MAX = BRIGHTNESS_MAX_DEF,
    parameter int COORD_BITS     = COORD_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [PIXEL_BITS-1:0]    pixel_x,
    input  logic [PIXEL_BITS-1:0]    pixel_y,
    input  logic [CHAN_BITS-1:0]     red_in,
    input  logic [CHAN_BITS-1:0]     green_in,
    input  logic [CHAN_BITS-1:0]     blue_in,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [IDX_BITS-1:0]      led_index,
    output logic [CHAN_BITS-1:0]     red_out,
    output logic [CHAN_BITS-1:0]     green_out,
    output logic [CHAN_BITS-1:0]     blue_out
);

    localparam int CW = COORD_BITS;

    logic [SEG_BITS-1:0]       seg_w_reg;
    logic [SEG_BITS-1:0]       seg_h_reg;
    logic [SEG_BITS-1:0]       seg_cols_reg;
    logic [LEVEL_BITS-1:0]     level_reg;
    logic [SEG_BITS-1:0]       w_eff;
    logic [SEG_BITS-1:0]       h_eff;
    logic                      advance;
    logic [COORD_MAX_BITS-1:0] x_ext;
    logic [COORD_MAX_BITS-1:0] y_ext;
    rgb_t                      rgb_src;
    rgb_t                      rgb_res;

    logic                valid_ch [0:CW];
    logic [CW-1:0]       x_dq_ch  [0:CW];
    logic [SEG_BITS-1:0] x_rem_ch [0:CW];
    logic [CW-1:0]       y_dq_ch  [0:CW];
    logic [SEG_BITS-1:0] y_rem_ch [0:CW];
    rgb_t                rgb_ch   [0:CW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_w_reg    <= SEG_WIDTH_RST;
            seg_h_reg    <= SEG_HEIGHT_RST;
            seg_cols_reg <= SEG_COLUMNS_RST;
            level_reg    <= BRIGHTNESS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SEG_WIDTH:   seg_w_reg    <= cfg_data[SEG_BITS-1:0];
                CFG_SEG_HEIGHT:  seg_h_reg    <= cfg_data[SEG_BITS-1:0];
                CFG_SEG_COLUMNS: seg_cols_reg <= cfg_data[SEG_BITS-1:0];
                CFG_BRIGHTNESS:  level_reg    <= cfg_data[LEVEL_BITS-1:0];
            endcase
        end
    end

    // zero segment size counts as one
    assign w_eff = (seg_w_reg == '0) ? SEG_BITS'(1) : seg_w_reg;
    assign h_eff = (seg_h_reg == '0) ? SEG_BITS'(1) : seg_h_reg;

    assign advance  = !out_valid || !out_stall;
    assign in_stall = !advance;

    assign x_ext     = COORD_MAX_BITS'(pixel_x);
    assign y_ext     = COORD_MAX_BITS'(pixel_y);
    assign rgb_src.r = red_in;
    assign rgb_src.g = green_in;
    assign rgb_src.b = blue_in;

    assign valid_ch[0] = in_valid;
    assign x_dq_ch[0]  = x_ext[CW-1:0];
    assign x_rem_ch[0] = '0;
    assign y_dq_ch[0]  = y_ext[CW-1:0];
    assign y_rem_ch[0] = '0;
    assign rgb_ch[0]   = rgb_src;

    for (genvar i = 0; i < CW; i++)
    begin : g_cell
        tlpm_div_cell #(
            .CW (CW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .w_div     (w_eff),
            .h_div     (h_eff),
            .valid_in  (valid_ch[i]),
            .x_dq_in   (x_dq_ch[i]),
            .x_rem_in  (x_rem_ch[i]),
            .y_dq_in   (y_dq_ch[i]),
            .y_rem_in  (y_rem_ch[i]),
            .rgb_in    (rgb_ch[i]),
            .valid_out (valid_ch[i+1]),
            .x_dq_out  (x_dq_ch[i+1]),
            .x_rem_out (x_rem_ch[i+1]),
            .y_dq_out  (y_dq_ch[i+1]),
            .y_rem_out (y_rem_ch[i+1]),
            .rgb_out   (rgb_ch[i+1])
        );
    end

    tlpm_out_pipe #(
        .CW             (CW),
        .BRIGHTNESS_MAX (BRIGHTNESS_MAX)
    ) u_out_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .valid_in  (valid_ch[CW]),
        .col_in    (x_dq_ch[CW]),
        .xr_in     (x_rem_ch[CW]),
        .row_in    (y_dq_ch[CW]),
        .yr_in     (y_rem_ch[CW]),
        .rgb_in    (rgb_ch[CW]),
        .w_eff     (w_eff),
        .h_eff     (h_eff),
        .cols      (seg_cols_reg),
        .level     (level_reg),
        .valid_out (out_valid),
        .idx_out   (led_index),
        .rgb_out   (rgb_res)
    );

    assign red_out   = rgb_res.r;
    assign green_out = rgb_res.g;
    assign blue_out  = rgb_res.b;

endmodule

// File: sim/pixel_map_checker.sv
module pixel_map_checker
    import tlpm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic [PIXEL_BITS-1:0]     pixel_x,
    input  logic [PIXEL_BITS-1:0]     pixel_y,
    input  logic [CHAN_BITS-1:0]      red_in,
    input  logic [CHAN_BITS-1:0]      green_in,
    input  logic [CHAN_BITS-1:0]      blue_in,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic [IDX_BITS-1:0]       led_index,
    input  logic [CHAN_BITS-1:0]      red_out,
    input  logic [CHAN_BITS-1:0]      green_out,
    input  logic [CHAN_BITS-1:0]      blue_out,
    output int                        mismatches,
    output int                        outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [IDX_BITS-1:0] pos;
        rgb_t                color;
    } led_item_t;

    logic [SEG_BITS-1:0]   seg_w_q;
    logic [SEG_BITS-1:0]   seg_h_q;
    logic [SEG_BITS-1:0]   seg_cols_q;
    logic [LEVEL_BITS-1:0] level_q;
    led_item_t             expected_leds[$];

    function automatic logic [CHAN_BITS-1:0] dim_channel(logic [CHAN_BITS-1:0] c);
        int unsigned v;
        if (level_q >= LEVEL_BITS'(BRIGHTNESS_MAX_DEF))
            return c;
        v = (int'(c) * int'(level_q)) / BRIGHTNESS_MAX_DEF;
        // lit channels never go fully dark
        if (v == 0 && c != '0)
            v = 1;
        return v[CHAN_BITS-1:0];
    endfunction

    function automatic led_item_t map_pixel(logic [PIXEL_BITS-1:0] x, logic [PIXEL_BITS-1:0] y,
                                            rgb_t c);
        longint unsigned xl;
        longint unsigned yl;
        longint unsigned w;
        longint unsigned h;
        longint unsigned col;
        longint unsigned row;
        longint unsigned seg;
        longint unsigned inner;
        longint unsigned full_pos;
        led_item_t       e;
        xl = 64'(x);
        yl = 64'(y);
        w = (seg_w_q == '0) ? 64'd1 : 64'(seg_w_q);
        h = (seg_h_q == '0) ? 64'd1 : 64'(seg_h_q);
        col = xl / w;
        row = yl / h;
        seg = col + row * 64'(seg_cols_q);
        inner = (xl - col * w) + (yl - row * h) * w;
        full_pos = inner + w * h * seg;
        e.pos = full_pos[IDX_BITS-1:0];
        e.color.r = dim_channel(c.r);
        e.color.g = dim_channel(c.g);
        e.color.b = dim_channel(c.b);
        return e;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        led_item_t e;
        rgb_t      c;
        if (!rst_n)
        begin
            seg_w_q = SEG_WIDTH_RST;
            seg_h_q = SEG_HEIGHT_RST;
            seg_cols_q = SEG_COLUMNS_RST;
            level_q = BRIGHTNESS_RST;
            expected_leds.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SEG_WIDTH:   seg_w_q = cfg_data[SEG_BITS-1:0];
                    CFG_SEG_HEIGHT:  seg_h_q = cfg_data[SEG_BITS-1:0];
                    CFG_SEG_COLUMNS: seg_cols_q = cfg_data[SEG_BITS-1:0];
                    CFG_BRIGHTNESS:  level_q = cfg_data[LEVEL_BITS-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                c.r = red_in;
                c.g = green_in;
                c.b = blue_in;
                expected_leds.push_back(map_pixel(pixel_x, pixel_y, c));
            end
            if (out_valid && !out_stall)
            begin
                if (expected_leds.size() == 0)
                begin
                    $error("result transaction with no pixel pending: led_index %0d", led_index);
                    mismatches++;
                end
                else
                begin
                    e = expected_leds.pop_front();
                    if (led_index !== e.pos)
                    begin
                        $error("led_index mismatch: expected %0d, got %0d", e.pos, led_index);
                        mismatches++;
                    end
                    if (red_out !== e.color.r)
                    begin
                        $error("red_out mismatch: expected %0d, got %0d", e.color.r, red_out);
                        mismatches++;
                    end
                    if (green_out !== e.color.g)
                    begin
                        $error("green_out mismatch: expected %0d, got %0d", e.color.g, green_out);
                        mismatches++;
                    end
                    if (blue_out !== e.color.b)
                    begin
                        $error("blue_out mismatch: expected %0d, got %0d", e.color.b, blue_out);
                        mismatches++;
                    end
                end
            end
            outstanding <= expected_leds.size();
        end
    end

endmodule

// File: sim/testbench.sv
module testbench;
    import tlpm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 64;
    localparam int PIPE_LATENCY = COORD_BITS_DEF + 4;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_SEG_WIDTH;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [PIXEL_BITS-1:0]     pixel_x = '0;
    logic [PIXEL_BITS-1:0]     pixel_y = '0;
    logic [CHAN_BITS-1:0]      red_in = '0;
    logic [CHAN_BITS-1:0]      green_in = '0;
    logic [CHAN_BITS-1:0]      blue_in = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [IDX_BITS-1:0]       led_index;
    logic [CHAN_BITS-1:0]      red_out;
    logic [CHAN_BITS-1:0]      green_out;
    logic [CHAN_BITS-1:0]      blue_out;
    int                        mismatches;
    int                        outstanding;
    int                        cycle_count = 0;
    bit                        hold_req = 1'b0;

    always #1 clk = ~clk;

    tiled_led_pixel_mapper_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .led_index (led_index),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

    pixel_map_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .led_index   (led_index),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_pixel(logic [PIXEL_BITS-1:0] x, logic [PIXEL_BITS-1:0] y,
                              logic [CHAN_BITS-1:0] r, logic [CHAN_BITS-1:0] g,
                              logic [CHAN_BITS-1:0] b);
        in_valid <= 1'b1;
        pixel_x <= x;
        pixel_y <= y;
        red_in <= r;
        green_in <= g;
        blue_in <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic pause(int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // one extra edge so the count includes the last accepted transaction
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
    endtask

    task automatic set_mapping(logic [7:0] w, logic [7:0] h, logic [7:0] cols,
                               logic [7:0] level);
        write_reg(CFG_SEG_WIDTH, w);
        write_reg(CFG_SEG_HEIGHT, h);
        write_reg(CFG_SEG_COLUMNS, cols);
        write_reg(CFG_BRIGHTNESS, level);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [PIXEL_BITS-1:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return PIXEL_BITS'($urandom_range(0, 63));
            1: return PIXEL_BITS'($urandom_range(4032, 4095));
            default: return PIXEL_BITS'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic logic [CHAN_BITS-1:0] rand_chan();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd255;
            default: return CHAN_BITS'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] rand_size();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'($urandom_range(64, 255));
            default: return 8'($urandom_range(1, 16));
        endcase
    endfunction

    function automatic logic [7:0] rand_level();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd254;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic stream_pixels(int count, bit back_to_back);
        int sent;
        int burst;
        int k;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 24);
            for (k = 0; k < burst && sent < count; k++)
            begin
                send_pixel(rand_coord(), rand_coord(), rand_chan(), rand_chan(), rand_chan());
                sent++;
            end
            if (!back_to_back && $urandom_range(0, 3) != 0)
                pause($urandom_range(1, 8));
        end
    endtask

    // output side backpressure
    initial
    begin : receiver
        int  mode;
        int  run;
        int  k;
        bit  hold_taken;
        hold_taken = 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                mode = $urandom_range(0, 4);
                run = $urandom_range(4, 40);
                for (k = 0; k < run; k++)
                begin
                    case (mode)
                        0: out_stall <= 1'b0;
                        1: out_stall <= ($urandom_range(0, 1) == 0);
                        2: out_stall <= ($urandom_range(0, 4) != 0);
                        3: out_stall <= ($urandom_range(0, 5) == 0);
                        default: out_stall <= (k < run / 2);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    initial
    begin : stimulus
        int phase;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset mapping: 8x8 segments, one column, full brightness
        send_pixel(12'd0, 12'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255);
        send_pixel(12'd7, 12'd8, 8'd1, 8'd128, 8'd254);
        send_pixel(12'd4095, 12'd0, 8'd1, 8'd0, 8'd255);
        send_pixel(12'd0, 12'd4095, 8'd170, 8'd85, 8'd1);
        drain();

        // smallest segments, brightness off
        set_mapping(8'd1, 8'd1, 8'd1, 8'd0);
        send_pixel(12'd0, 12'd0, 8'd255, 8'd1, 8'd0);
        send_pixel(12'd4095, 12'd4095, 8'd1, 8'd2, 8'd254);
        drain();

        set_mapping(8'd64, 8'd64, 8'd64, 8'd255);
        send_pixel(12'd4095, 12'd4095, 8'd12, 8'd200, 8'd0);
        send_pixel(12'd63, 12'd64, 8'd255, 8'd0, 8'd128);
        drain();

        // zero sizes and zero columns
        set_mapping(8'd0, 8'd0, 8'd0, 8'd1);
        send_pixel(12'd4095, 12'd4095, 8'd255, 8'd254, 8'd1);
        send_pixel(12'd0, 12'd5, 8'd128, 8'd127, 8'd0);
        drain();

        // largest sizes, index wraps past 24 bits
        set_mapping(8'd127, 8'd127, 8'd127, 8'd254);
        send_pixel(12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255);
        send_pixel(12'd126, 12'd127, 8'd1, 8'd2, 8'd3);
        drain();

        // upper data bit dropped by the 7-bit size registers
        set_mapping(8'hFF, 8'h80, 8'hC0, 8'd128);
        send_pixel(12'd2730, 12'd1365, 8'd170, 8'd85, 8'd2);
        send_pixel(12'd1365, 12'd2730, 8'd85, 8'd170, 8'd253);
        drain();

        for (phase = 0; phase < 10; phase++)
        begin
            set_mapping(rand_size(), rand_size(),
                        8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(1, 8)),
                        rand_level());
            if (phase == 0)
            begin
                hold_req = 1'b1;
                stream_pixels(100, 1'b1);
            end
            else
                stream_pixels(78, 1'b0);
            drain();
        end

        repeat (PIPE_LATENCY + 4) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
